// ----- rtl/acg_pkg.sv -----
// Shared types and constants for the adaptive clock governor.
`timescale 1ns / 1ps

package acg_pkg;

  // Step sizes in MHz and the cool margin in 1/16 degree C.
  localparam int unsigned HardStepMhz    = 25;
  localparam int unsigned GentleStepMhz  = 10;
  localparam int unsigned RecoverStepMhz = 5;
  localparam int unsigned CoolMargin     = 48;

  // Register file reset values.
  localparam logic        EnabledRst  = 1'b1;
  localparam logic [11:0] CeilingRst  = 12'd500;
  localparam logic [11:0] FloorRst    = 12'd375;
  localparam logic [14:0] ErrTgtRst   = 15'd256;
  localparam logic [14:0] ErrCritRst  = 15'd768;
  localparam logic [11:0] GuardRst    = 12'd1040;
  localparam logic [15:0] IntervalRst = 16'd5000;
  localparam logic [7:0]  RecoverRst  = 8'd6;

  // Largest value the stable counter holds.
  localparam logic [7:0] StableMax = 8'd255;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_ENABLED  = 3'd0,
    REG_CEILING  = 3'd1,
    REG_FLOOR    = 3'd2,
    REG_ERR_TGT  = 3'd3,
    REG_ERR_CRIT = 3'd4,
    REG_GUARD    = 3'd5,
    REG_INTERVAL = 3'd6,
    REG_RECOVER  = 3'd7
  } reg_idx_t;

  // Current configuration as seen by the decision logic.
  typedef struct packed {
    logic        enabled;
    logic [11:0] ceiling;
    logic [11:0] floor_mhz;
    logic [14:0] err_tgt;
    logic [14:0] err_crit;
    logic [11:0] guard;
    logic [15:0] interval;
    logic [7:0]  recover;
  } cfg_t;

  // Governor state carried from one sample to the next.
  typedef struct packed {
    logic [11:0] target;
    logic [7:0]  stable;
    logic [47:0] last_time;
  } gov_state_t;

  // One sample.
  typedef struct packed {
    logic [47:0]        time_ms;
    logic signed [12:0] chip_temp;
    logic [14:0]        error_rate;
  } sample_t;

  // One result.
  typedef struct packed {
    logic        changed;
    logic        decided;
    logic [11:0] target_mhz;
  } result_t;

endpackage

// ----- rtl/acg_cfg_regs.sv -----
// Configuration register file of the adaptive clock governor.
`timescale 1ns / 1ps

module acg_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  acg_pkg::reg_idx_t   wr_idx,
  input  logic [15:0]         wr_data,
  output acg_pkg::cfg_t       cfg,
  output logic                ceiling_wr
);

  acg_pkg::cfg_t cfg_r;
  acg_pkg::cfg_t cfg_nxt;

  // Register write decode.
  always_comb begin
    cfg_nxt    = cfg_r;
    ceiling_wr = 1'b0;
    if (wr_en) begin
      unique case (wr_idx)
        acg_pkg::REG_ENABLED:  cfg_nxt.enabled   = wr_data[0];
        acg_pkg::REG_CEILING: begin
          cfg_nxt.ceiling = wr_data[11:0];
          ceiling_wr      = 1'b1;
        end
        acg_pkg::REG_FLOOR:    cfg_nxt.floor_mhz = wr_data[11:0];
        acg_pkg::REG_ERR_TGT:  cfg_nxt.err_tgt   = wr_data[14:0];
        acg_pkg::REG_ERR_CRIT: cfg_nxt.err_crit  = wr_data[14:0];
        acg_pkg::REG_GUARD:    cfg_nxt.guard     = wr_data[11:0];
        acg_pkg::REG_INTERVAL: cfg_nxt.interval  = wr_data;
        acg_pkg::REG_RECOVER:  cfg_nxt.recover   = wr_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enabled   <= acg_pkg::EnabledRst;
      cfg_r.ceiling   <= acg_pkg::CeilingRst;
      cfg_r.floor_mhz <= acg_pkg::FloorRst;
      cfg_r.err_tgt   <= acg_pkg::ErrTgtRst;
      cfg_r.err_crit  <= acg_pkg::ErrCritRst;
      cfg_r.guard     <= acg_pkg::GuardRst;
      cfg_r.interval  <= acg_pkg::IntervalRst;
      cfg_r.recover   <= acg_pkg::RecoverRst;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/acg_decide.sv -----
// Decision logic: next target, stable count and decision time for one sample.
`timescale 1ns / 1ps

module acg_decide (
  input  acg_pkg::cfg_t       cfg,
  input  acg_pkg::gov_state_t cur,
  input  acg_pkg::sample_t    smp,
  output acg_pkg::gov_state_t nxt,
  output acg_pkg::result_t    res
);

  logic [48:0]        elapsed;
  logic               hold;
  logic signed [13:0] temp;
  logic signed [13:0] guard;
  logic signed [13:0] cool_lim;
  logic               valid_t;
  logic               hot;
  logic               cool;
  logic [7:0]         stable_inc;
  logic signed [13:0] t_base;
  logic signed [13:0] t_step;
  logic signed [13:0] t_floor;
  logic signed [13:0] t_ceil;
  logic [11:0]        t_clamped;
  logic [7:0]         stable_new;

  // Time since the last decision; a borrow means time went backwards.
  assign elapsed = {1'b0, smp.time_ms} - {1'b0, cur.last_time};
  assign hold    = (cur.last_time != 48'd0) &&
                   (elapsed[48] || (elapsed[47:0] < {32'd0, cfg.interval}));

  // Temperature classification.
  assign temp     = 14'(smp.chip_temp);
  assign guard    = signed'({2'b00, cfg.guard});
  assign cool_lim = guard - 14'(acg_pkg::CoolMargin);
  assign valid_t  = temp > 14'sd0;
  assign hot      = valid_t && (temp > guard);
  assign cool     = !valid_t || (temp < cool_lim);

  assign stable_inc = (cur.stable < acg_pkg::StableMax) ? cur.stable + 8'd1 : cur.stable;
  assign t_base     = signed'({2'b00, cur.target});
  assign t_floor    = signed'({2'b00, cfg.floor_mhz});
  assign t_ceil     = signed'({2'b00, cfg.ceiling});

  // Pick the step and the new stable count.
  always_comb begin
    if (smp.error_rate > cfg.err_crit) begin
      t_step     = t_base - 14'(acg_pkg::HardStepMhz);
      stable_new = 8'd0;
    end else if ((smp.error_rate > cfg.err_tgt) || hot) begin
      t_step     = t_base - 14'(acg_pkg::GentleStepMhz);
      stable_new = 8'd0;
    end else if ((stable_inc >= cfg.recover) && cool) begin
      t_step     = t_base + 14'(acg_pkg::RecoverStepMhz);
      stable_new = 8'd0;
    end else begin
      t_step     = t_base;
      stable_new = stable_inc;
    end
  end

  // When the two cross, a step below the floor gives the floor and any other step gives the ceiling.
  always_comb begin
    if (t_step < t_floor) begin
      t_clamped = cfg.floor_mhz;
    end else if (t_step > t_ceil) begin
      t_clamped = cfg.ceiling;
    end else begin
      t_clamped = t_step[11:0];
    end
  end

  // Disabled, held or decided.
  always_comb begin
    nxt         = cur;
    res.decided = 1'b0;
    if (!cfg.enabled) begin
      nxt.target = cfg.ceiling;
    end else if (!hold) begin
      nxt.target    = t_clamped;
      nxt.stable    = stable_new;
      nxt.last_time = smp.time_ms;
      res.decided   = 1'b1;
    end
    res.target_mhz = nxt.target;
    res.changed    = nxt.target != cur.target;
  end

endmodule

// ----- rtl/adaptive_clock_governor_top.sv -----
// Top level of the adaptive clock governor.
`timescale 1ns / 1ps
// Adaptive clock governor.
// Input stream: one word per sample carrying the error rate, the chip
// temperature and a millisecond timestamp. Output stream: one word per
// sample with the new frequency target and the decided and changed flags.
// Configuration channel: writes one of eight registers by index; cfg_ready
// is always high. The user must write registers only while no sample is in flight; the block does not enforce this.
// Writing the ceiling also loads it into the target and clears the stable
// count.
// A sample passes through the input register, then through the decision
// logic into the output register, which also updates the governor state.
// One sample per cycle is sustained while out_tready stays high, limited
// by the state feedback loop.
// When the receiver stalls, the output word holds, the input register fills
// and in_tready falls only once both stages are occupied.
// Reset loads the register defaults, sets the target to 500 MHz, clears the
// stable count and the decision time, and empties both stages.

module adaptive_clock_governor_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [14:0] error_rate, [27:15] chip_temp, [75:28] time_ms, [79:76] zero
  input  logic [79:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [11:0] target_mhz, [12] decided, [13] changed, [15:14] zero
  output logic [15:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  acg_pkg::cfg_t       cfg;
  logic                ceiling_wr;
  acg_pkg::sample_t    smp_r;
  logic                smp_vld_r;
  acg_pkg::gov_state_t st_r;
  acg_pkg::gov_state_t st_nxt;
  acg_pkg::result_t    res;
  acg_pkg::result_t    res_r;
  logic                out_vld_r;
  logic                out_free;
  logic                adv;

  assign cfg_ready = 1'b1;

  acg_cfg_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (cfg_valid),
    .wr_idx     (acg_pkg::reg_idx_t'(cfg_addr)),
    .wr_data    (cfg_wdata),
    .cfg        (cfg),
    .ceiling_wr (ceiling_wr)
  );

  // Handshake: output register frees when taken, input register when it advances.
  assign out_free  = !out_vld_r || out_tready;
  assign adv       = smp_vld_r && out_free;
  assign in_tready = !smp_vld_r || out_free;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_vld_r <= 1'b0;
    end else if (in_tready) begin
      smp_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      smp_r <= acg_pkg::sample_t'(in_tdata[75:0]);
    end
  end

  acg_decide u_decide (
    .cfg (cfg),
    .cur (st_r),
    .smp (smp_r),
    .nxt (st_nxt),
    .res (res)
  );

  // Governor state; a ceiling write reloads the target.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.target    <= acg_pkg::CeilingRst;
      st_r.stable    <= 8'd0;
      st_r.last_time <= 48'd0;
    end else if (cfg_valid && ceiling_wr) begin
      st_r.target <= cfg_wdata[11:0];
      st_r.stable <= 8'd0;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= smp_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {2'b00, res_r};

endmodule

// ----- rtl/acg_checker.sv -----
// Port-level checks for the adaptive clock governor, bound to the top level.
`timescale 1ns / 1ps

module acg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // A stalled output word stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed while stalled");

  // Both stages come out of reset empty.
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_tvalid && in_tready)
    else $error("pipeline not empty after reset");

  // A word taken behind a stalled output fills both stages.
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && out_tvalid && !out_tready |=> out_tready || !in_tready)
    else $error("input accepted with both stages full");

  // A word accepted while the output is empty shows up as a valid output word after the input and output registers.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |-> ##2 out_tvalid)
    else $error("result missing two cycles after acceptance");

endmodule

bind adaptive_clock_governor_top acg_checker u_acg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
